### sv/shortest_path_distance_defines.svh
// Assertion macros used by the shortest path distance checker.
`ifndef SHORTEST_PATH_DISTANCE_DEFINES_SVH
`define SHORTEST_PATH_DISTANCE_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define SPD_ASSERT_NOW(lbl, clk, rst_n, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) else $error(msg);

// Next-cycle implication.
`define SPD_ASSERT_NEXT(lbl, clk, rst_n, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) else $error(msg);

`endif

### sv/spd_pkg.sv
// Shared constants, codes and types of the shortest path distance block.
package spd_pkg;

  localparam int MAX_NODES   = 64;
  localparam int MAX_EDGES   = 1024;
  localparam int WEIGHT_BITS = 16;
  localparam int DIST_BITS   = 24;

  localparam int NODE_W  = $clog2(MAX_NODES);
  localparam int CNT_W   = $clog2(MAX_NODES + 1);
  localparam int EADDR_W = $clog2(MAX_EDGES);
  localparam int ELOAD_W = $clog2(MAX_EDGES + 1);

  // Fixed port field widths
  localparam int KIND_W     = 2;
  localparam int FNODE_W    = 6;
  localparam int FWEIGHT_W  = 16;
  localparam int ODIST_W    = 24;
  localparam int CFG_W      = 7;

  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_CLEAR = 2'd0;
  localparam kind_t KIND_ADD   = 2'd1;
  localparam kind_t KIND_QUERY = 2'd2;

  typedef struct packed {
    logic [FNODE_W-1:0]     tail;
    logic [FNODE_W-1:0]     head;
    logic [WEIGHT_BITS-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] cost;
    logic                 reached;
    logic                 settled;
  } node_t;

  typedef struct packed {
    logic [FNODE_W-1:0] src;
    logic [FNODE_W-1:0] dst;
    logic [CNT_W-1:0]   n;
    logic [ELOAD_W-1:0] loaded;
  } query_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] cost;
    logic                 unreach;
    logic                 ovf;
  } result_t;

endpackage

### sv/spd_if.sv
// Channel interfaces: command input, result output and configuration write.
interface spd_in_if import spd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [FNODE_W-1:0]   edge_tail;
  logic [FNODE_W-1:0]   edge_head;
  logic [FWEIGHT_W-1:0] edge_weight;
  logic [FNODE_W-1:0]   source_node;
  logic [FNODE_W-1:0]   target_node;

  modport source (output valid, kind, edge_tail, edge_head, edge_weight, source_node,
                  target_node, input ready);
  modport sink   (input valid, kind, edge_tail, edge_head, edge_weight, source_node,
                  target_node, output ready);
endinterface

interface spd_out_if import spd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ODIST_W-1:0] distance;
  logic               unreachable;
  logic               overflow;
  logic               edge_store_full;

  modport source (output valid, distance, unreachable, overflow, edge_store_full,
                  input ready);
  modport sink   (input valid, distance, unreachable, overflow, edge_store_full,
                  output ready);
endinterface

interface spd_cfg_if import spd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] node_count;

  modport source (output valid, node_count, input ready);
  modport sink   (input valid, node_count, output ready);
endinterface

### sv/spd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module spd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/spd_search.sv
// Query engine: node table in RAM, linear min scan and edge relaxation.
module spd_search import spd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  query_t             query,
  output logic               idle,
  output logic               done,
  input  logic               take,
  output result_t            result,
  output logic [EADDR_W-1:0] edge_raddr,
  input  edge_t              edge_rdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_SCAN, S_EADDR, S_EDATA, S_NDATA, S_DONE
  } state_t;

  state_t               state_r;
  logic [FNODE_W-1:0]   src_r, dst_r;
  logic [CNT_W-1:0]     n_r;
  logic [ELOAD_W-1:0]   loaded_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 pend_r;
  logic [NODE_W-1:0]    pend_idx_r;
  logic                 found_r;
  logic [NODE_W-1:0]    best_r;
  logic [DIST_BITS-1:0] best_dist_r;
  logic [ELOAD_W-1:0]   k_r;
  logic [NODE_W-1:0]    head_r;
  logic [WEIGHT_BITS-1:0] w_r;
  logic                 ovf_r;
  result_t              res_r;

  logic                 n_we;
  logic [NODE_W-1:0]    n_waddr, n_raddr;
  node_t                n_wdata, n_rdata;
  logic [DIST_BITS:0]   sum;
  logic                 sat;
  logic [DIST_BITS-1:0] sum_d;
  logic                 scan_end, better, edge_hit, relax;

  spd_ram #(.WIDTH($bits(node_t)), .DEPTH(MAX_NODES)) u_node_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .raddr (n_raddr),
    .rdata (n_rdata)
  );

  assign sum   = {1'b0, best_dist_r} + (DIST_BITS + 1)'(w_r);
  assign sat   = sum[DIST_BITS];
  assign sum_d = sat ? DIST_MAX : sum[DIST_BITS-1:0];
  assign relax = !n_rdata.reached || (sum_d < n_rdata.cost);

  assign scan_end = (cnt_r == n_r) && !pend_r;
  assign better   = pend_r && n_rdata.reached && !n_rdata.settled &&
                    (!found_r || (n_rdata.cost < best_dist_r));
  assign edge_hit = (edge_rdata.tail == FNODE_W'(best_r)) &&
                    (CNT_W'(edge_rdata.head) < n_r);

  assign idle       = (state_r == S_IDLE);
  assign done       = (state_r == S_DONE);
  assign result     = res_r;
  assign edge_raddr = k_r[EADDR_W-1:0];

  always_comb begin
    n_we    = 1'b0;
    n_waddr = cnt_r[NODE_W-1:0];
    n_wdata = '0;
    n_raddr = cnt_r[NODE_W-1:0];
    unique case (state_r)
      S_CLEAR: begin
        n_we            = 1'b1;
        n_wdata.reached = (cnt_r[NODE_W-1:0] == NODE_W'(src_r));
      end
      S_SCAN: begin
        if (scan_end && found_r) begin
          n_we    = 1'b1;
          n_waddr = best_r;
          n_wdata = '{cost: best_dist_r, reached: 1'b1, settled: 1'b1};
        end
      end
      S_EDATA: begin
        n_raddr = NODE_W'(edge_rdata.head);
      end
      S_NDATA: begin
        n_we    = relax;
        n_waddr = head_r;
        n_wdata = '{cost: sum_d, reached: 1'b1, settled: n_rdata.settled};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
      found_r <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            src_r    <= query.src;
            dst_r    <= query.dst;
            n_r      <= query.n;
            loaded_r <= query.loaded;
            ovf_r    <= 1'b0;
            cnt_r    <= '0;
            if ((CNT_W'(query.src) >= query.n) || (CNT_W'(query.dst) >= query.n)) begin
              res_r   <= '{cost: '0, unreach: 1'b1, ovf: 1'b0};
              state_r <= S_DONE;
            end else begin
              state_r <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(MAX_NODES - 1)) begin
            cnt_r   <= '0;
            pend_r  <= 1'b0;
            found_r <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt_r < n_r) begin
            cnt_r <= cnt_r + 1'b1;
          end
          pend_r     <= (cnt_r < n_r);
          pend_idx_r <= cnt_r[NODE_W-1:0];
          if (better) begin
            found_r     <= 1'b1;
            best_r      <= pend_idx_r;
            best_dist_r <= n_rdata.cost;
          end
          if (scan_end) begin
            if (!found_r) begin
              res_r   <= '{cost: '0, unreach: 1'b1, ovf: ovf_r};
              state_r <= S_DONE;
            end else if (best_r == NODE_W'(dst_r)) begin
              res_r   <= '{cost: best_dist_r, unreach: 1'b0, ovf: ovf_r};
              state_r <= S_DONE;
            end else begin
              k_r     <= '0;
              state_r <= S_EADDR;
            end
          end
        end
        S_EADDR: begin
          if (k_r == loaded_r) begin
            cnt_r   <= '0;
            pend_r  <= 1'b0;
            found_r <= 1'b0;
            state_r <= S_SCAN;
          end else begin
            state_r <= S_EDATA;
          end
        end
        S_EDATA: begin
          if (edge_hit) begin
            head_r  <= NODE_W'(edge_rdata.head);
            w_r     <= edge_rdata.weight;
            state_r <= S_NDATA;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_EADDR;
          end
        end
        S_NDATA: begin
          if (sat) begin
            ovf_r <= 1'b1;
          end
          k_r     <= k_r + 1'b1;
          state_r <= S_EADDR;
        end
        S_DONE: begin
          if (take) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/shortest_path_distance.sv
// Top level of the single-pair shortest path block.
//
// Clear and add-edge commands complete in the cycle of their transfer and give
// no result. A query searches with Dijkstra's rule over the stored edge list
// and returns one result. A query first rewrites the 64-entry node table,
// then repeats a min scan over the node table until the target is settled or
// no reached node is left, with a pass over the edge store after each settled
// node other than the target to relax the edges leaving it. The edge store
// and the node table are single-port-read RAMs, and that sequential pass is
// what sets the query time. A query whose source or target is out of range
// answers without rewriting the table or searching. The input stays not ready
// while a query runs; a finished result waits in the output register while
// the next command is accepted.
module shortest_path_distance import spd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  spd_in_if.sink     in_ch,
  spd_out_if.source  out_ch,
  spd_cfg_if.sink    cfg_ch
);

  logic [CFG_W-1:0]   node_count_r;
  logic [CNT_W-1:0]   n_use;
  logic [ELOAD_W-1:0] loaded_r;
  logic               dropped_r;

  logic               in_xfer, add_we, eng_idle, eng_done, res_take;
  query_t             query;
  result_t            eng_res;
  logic [EADDR_W-1:0] edge_raddr;
  edge_t              edge_wdata, edge_rdata;

  logic                 out_valid_r;
  logic [ODIST_W-1:0]   out_dist_r;
  logic                 out_unreach_r, out_ovf_r, out_full_r;

  // Config register is always writable
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CFG_W'(MAX_NODES);
    end else if (cfg_ch.valid) begin
      node_count_r <= cfg_ch.node_count;
    end
  end

  // Zero acts as one node, oversize clamps to the table size
  always_comb begin
    priority if (node_count_r == '0) begin
      n_use = CNT_W'(1);
    end else if (node_count_r > CFG_W'(MAX_NODES)) begin
      n_use = CNT_W'(MAX_NODES);
    end else begin
      n_use = CNT_W'(node_count_r);
    end
  end

  assign in_ch.ready = eng_idle;
  assign in_xfer     = in_ch.valid && eng_idle;
  assign add_we      = in_xfer && (in_ch.kind == KIND_ADD) &&
                       (loaded_r < ELOAD_W'(MAX_EDGES));

  assign edge_wdata = '{tail: in_ch.edge_tail, head: in_ch.edge_head,
                        weight: WEIGHT_BITS'(in_ch.edge_weight)};

  // Edge store bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r  <= '0;
      dropped_r <= 1'b0;
    end else if (in_xfer) begin
      unique case (in_ch.kind)
        KIND_CLEAR: begin
          loaded_r  <= '0;
          dropped_r <= 1'b0;
        end
        KIND_ADD: begin
          if (add_we) begin
            loaded_r <= loaded_r + 1'b1;
          end else begin
            dropped_r <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  spd_ram #(.WIDTH($bits(edge_t)), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (add_we),
    .waddr (loaded_r[EADDR_W-1:0]),
    .wdata (edge_wdata),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  assign query = '{src: in_ch.source_node, dst: in_ch.target_node, n: n_use,
                   loaded: loaded_r};

  spd_search u_search (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_xfer && (in_ch.kind == KIND_QUERY)),
    .query      (query),
    .idle       (eng_idle),
    .done       (eng_done),
    .take       (res_take),
    .result     (eng_res),
    .edge_raddr (edge_raddr),
    .edge_rdata (edge_rdata)
  );

  // Result register; the engine holds its result until this slot frees
  assign res_take = eng_done && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (res_take) begin
        out_valid_r   <= 1'b1;
        out_dist_r    <= ODIST_W'(eng_res.cost);
        out_unreach_r <= eng_res.unreach;
        out_ovf_r     <= eng_res.ovf;
        out_full_r    <= dropped_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.distance        = out_dist_r;
  assign out_ch.unreachable     = out_unreach_r;
  assign out_ch.overflow        = out_ovf_r;
  assign out_ch.edge_store_full = out_full_r;

endmodule

### sv/spd_checker.sv
// Port-level checker for the shortest path distance block, with its bind.
`include "shortest_path_distance_defines.svh"

module spd_checker import spd_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [KIND_W-1:0]  in_kind,
  input logic               out_valid,
  input logic               out_ready,
  input logic [ODIST_W-1:0] out_distance,
  input logic               out_unreachable
);

  `SPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_distance), "result changed while stalled")
  `SPD_ASSERT_NOW(a_unreach_zero, clk, rst_n, out_valid && out_unreachable, out_distance == '0, "unreachable result with nonzero distance")
  `SPD_ASSERT_NEXT(a_query_busy, clk, rst_n, in_valid && in_ready && (in_kind == KIND_QUERY), !in_ready, "input ready right after a query transfer")

endmodule

bind shortest_path_distance spd_checker u_spd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_kind         (in_ch.kind),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_distance    (out_ch.distance),
  .out_unreachable (out_ch.unreachable)
);
